>>> sv/obce_pkg.sv
package obce_pkg;

  localparam int Q          = 4;
  localparam int DIGITS     = 6;
  localparam int DIG_W      = 2;
  localparam int WORD_W     = DIGITS * DIG_W;
  localparam int DEPTH      = 4096;
  localparam int MAX_ORBITS = 64;
  localparam int ORB_W      = 6;
  localparam int CNT_W      = 9;
  localparam int CNT_MAX    = 511;
  localparam int TOT_W      = 13;
  localparam int DELTA_W    = 14;
  localparam int RAD_W      = 3;
  localparam int POS_W      = 3;
  localparam int IN_W       = 32;
  localparam int OUT_W      = 32;
  localparam int PC_W       = 3;

  typedef enum logic [1:0] {
    CMD_PLACE  = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_EST    = 2'd2,
    CMD_COMMIT = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [ORB_W-1:0]   orbit;
    logic [WORD_W-1:0]  word;
    logic [POS_W-1:0]   position;
    logic [DIG_W-1:0]   new_digit;
    logic               skip;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_out_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

  function automatic logic [PC_W-1:0] popcnt(input logic [DIGITS-1:0] m);
    logic [PC_W-1:0] n;
    n = '0;
    for (int i = 0; i < DIGITS; i++) begin
      n = n + PC_W'(m[i]);
    end
    return n;
  endfunction

endpackage

>>> sv/obce_ram.sv
module obce_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/obce_front.sv
module obce_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [obce_pkg::IN_W-1:0]    s_axis_tdata,
  input  obce_pkg::back_stat_t         stat,
  output obce_pkg::queue_out_t         q
);

  obce_pkg::entry_t mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  obce_pkg::entry_t dec;
  logic             accept;

  // field unpack and classification
  always_comb begin
    dec.cmd       = obce_pkg::cmd_t'(s_axis_tdata[1:0]);
    dec.orbit     = s_axis_tdata[7:2];
    dec.word      = s_axis_tdata[19:8];
    dec.position  = s_axis_tdata[22:20];
    dec.new_digit = s_axis_tdata[24:23];
    dec.skip      = (int'(dec.orbit) >= obce_pkg::MAX_ORBITS) ||
                    (((dec.cmd == obce_pkg::CMD_EST) || (dec.cmd == obce_pkg::CMD_COMMIT)) &&
                     (int'(dec.position) >= obce_pkg::DIGITS));
  end

  assign s_axis_tready = (count != 2'd2) && !stat.clearing;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign q.valid       = (count != 2'd0);
  assign q.entry       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wr_ptr] <= dec;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= !wr_ptr;
      end
      if (stat.pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(accept) - 2'(stat.pop);
    end
  end

endmodule

>>> sv/obce_back.sv
module obce_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [obce_pkg::RAD_W-1:0]    radius,
  input  obce_pkg::queue_out_t          q,
  output obce_pkg::back_stat_t          stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [obce_pkg::DELTA_W-1:0] out_delta,
  output logic [obce_pkg::TOT_W-1:0]    out_total
);

  localparam int AW = $clog2(obce_pkg::DEPTH);
  localparam int OW = $clog2(obce_pkg::MAX_ORBITS);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LOAD, ST_BALL, ST_MASK,
    ST_RDA, ST_UPA, ST_RDB, ST_UPB, ST_NXT, ST_FIN
  } state_t;

  state_t                             state;
  obce_pkg::entry_t                   cur;
  logic [obce_pkg::WORD_W-1:0]        e;
  logic [obce_pkg::DIG_W-1:0]         d;
  logic [obce_pkg::DIGITS-1:0]        mask;
  logic [obce_pkg::DIGITS-1:0][obce_pkg::DIG_W-1:0] k;
  logic signed [obce_pkg::DELTA_W-1:0] delta;
  logic [obce_pkg::TOT_W-1:0]         total;
  logic [AW-1:0]                      clr_addr;

  logic                               cnt_we;
  logic [AW-1:0]                      cnt_waddr;
  logic [AW-1:0]                      cnt_raddr;
  logic [obce_pkg::CNT_W-1:0]         cnt_wdata;
  logic [obce_pkg::CNT_W-1:0]         cnt_rdata;
  logic                               rep_we;
  logic [OW-1:0]                      rep_waddr;
  logic [obce_pkg::WORD_W-1:0]        rep_wdata;
  logic [obce_pkg::WORD_W-1:0]        rep_rdata;

  logic [obce_pkg::DIGITS-1:0][obce_pkg::DIG_W-1:0] c_dig;
  logic [obce_pkg::DIGITS-1:0][obce_pkg::DIG_W-1:0] a_dig;
  logic [obce_pkg::DIGITS-1:0][obce_pkg::DIG_W-1:0] b_dig;
  logic [obce_pkg::DIGITS-1:0][obce_pkg::DIG_W-1:0] e_dig;
  logic [obce_pkg::DIGITS-1:0][obce_pkg::DIG_W-1:0] k_next;
  logic                               carry;
  logic [obce_pkg::DIG_W-1:0]         nv;
  logic signed [4:0]                  rad;
  logic [obce_pkg::PC_W-1:0]          pc;
  logic                               mask_ok;
  logic                               is_move;
  logic                               writes;
  logic signed [obce_pkg::DELTA_W-1:0] contrib;
  logic [obce_pkg::CNT_W-1:0]         cnt_new;
  logic signed [obce_pkg::DELTA_W+1:0] tsum;
  logic                               pop;

  // digit j sits at the most significant end for j = 0; digit sums wrap mod Q
  always_comb begin
    for (int j = 0; j < obce_pkg::DIGITS; j++) begin
      e_dig[j] = e[obce_pkg::DIG_W*(obce_pkg::DIGITS-1-j) +: obce_pkg::DIG_W];
      c_dig[j] = e_dig[j] + d;
      if (mask[obce_pkg::DIGITS-1-j]) begin
        a_dig[j] = (k[j] < c_dig[j]) ? k[j] : k[j] + 1'b1;
      end else begin
        a_dig[j] = c_dig[j];
      end
    end
    nv = cur.new_digit + d;
    b_dig = a_dig;
    b_dig[cur.position] = nv;
  end

  // odometer over the chosen positions, last position fastest
  always_comb begin
    k_next = k;
    carry  = 1'b1;
    for (int j = obce_pkg::DIGITS - 1; j >= 0; j--) begin
      if (mask[obce_pkg::DIGITS-1-j] && carry) begin
        if (k[j] == obce_pkg::DIG_W'(obce_pkg::Q - 2)) begin
          k_next[j] = '0;
        end else begin
          k_next[j] = k[j] + 1'b1;
          carry     = 1'b0;
        end
      end
    end
  end

  assign is_move = (cur.cmd == obce_pkg::CMD_EST) || (cur.cmd == obce_pkg::CMD_COMMIT);
  assign writes  = (cur.cmd != obce_pkg::CMD_EST);
  assign rad     = $signed({2'b00, radius}) - ((d != '0) ? 5'sd1 : 5'sd0);
  assign pc      = obce_pkg::popcnt(mask);
  assign mask_ok = is_move ?
                   (($signed({2'b00, pc}) == rad) &&
                    !mask[obce_pkg::DIGITS-1-int'(cur.position)]) :
                   ($signed({2'b00, pc}) <= rad);

  // counter update for the point under work
  always_comb begin
    contrib = '0;
    cnt_new = cnt_rdata;
    if ((state == ST_UPB) || ((state == ST_UPA) && (cur.cmd == obce_pkg::CMD_PLACE))) begin
      if (cnt_rdata == '0) begin
        contrib = -obce_pkg::DELTA_W'(1);
      end
      if (cnt_rdata != obce_pkg::CNT_W'(obce_pkg::CNT_MAX)) begin
        cnt_new = cnt_rdata + 1'b1;
      end
    end else begin
      if (cnt_rdata == obce_pkg::CNT_W'(1)) begin
        contrib = obce_pkg::DELTA_W'(1);
      end
      if (cnt_rdata != '0) begin
        cnt_new = cnt_rdata - 1'b1;
      end
    end
  end

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = a_dig;
    cnt_wdata = cnt_new;
    cnt_raddr = (state == ST_RDB) ? AW'(b_dig) : AW'(a_dig);
    if (state == ST_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_addr;
      cnt_wdata = '0;
    end else if (state == ST_UPA) begin
      cnt_we = writes;
    end else if (state == ST_UPB) begin
      cnt_we    = writes;
      cnt_waddr = b_dig;
    end
  end

  always_comb begin
    rep_we    = 1'b0;
    rep_waddr = cur.orbit;
    rep_wdata = cur.word;
    if ((state == ST_LOAD) && (cur.cmd == obce_pkg::CMD_PLACE)) begin
      rep_we = 1'b1;
    end else if ((state == ST_FIN) && !out_valid && !cur.skip &&
                 (cur.cmd == obce_pkg::CMD_COMMIT)) begin
      rep_we = 1'b1;
      for (int j = 0; j < obce_pkg::DIGITS; j++) begin
        if (j == int'(cur.position)) begin
          rep_wdata[obce_pkg::DIG_W*(obce_pkg::DIGITS-1-j) +: obce_pkg::DIG_W] =
            cur.new_digit;
        end else begin
          rep_wdata[obce_pkg::DIG_W*(obce_pkg::DIGITS-1-j) +: obce_pkg::DIG_W] = e_dig[j];
        end
      end
    end
  end

  assign pop           = (state == ST_IDLE) && q.valid;
  assign stat.pop      = pop;
  assign stat.clearing = (state == ST_CLEAR);
  assign tsum          = $signed({3'b000, total}) + delta;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      total     <= obce_pkg::TOT_W'(obce_pkg::DEPTH);
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (&clr_addr) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q.valid) begin
            cur   <= q.entry;
            delta <= '0;
            state <= q.entry.skip ? ST_FIN : ST_LOAD;
          end
        end
        ST_LOAD: begin
          e     <= (cur.cmd == obce_pkg::CMD_PLACE) ? cur.word : rep_rdata;
          d     <= '0;
          state <= ST_BALL;
        end
        ST_BALL: begin
          if (rad < 0) begin
            if (d == obce_pkg::DIG_W'(obce_pkg::Q - 1)) begin
              state <= ST_FIN;
            end else begin
              d <= d + 1'b1;
            end
          end else begin
            mask  <= '1;
            state <= ST_MASK;
          end
        end
        ST_MASK: begin
          if (mask_ok) begin
            k     <= '0;
            state <= ST_RDA;
          end else if (mask == '0) begin
            if (d == obce_pkg::DIG_W'(obce_pkg::Q - 1)) begin
              state <= ST_FIN;
            end else begin
              d     <= d + 1'b1;
              state <= ST_BALL;
            end
          end else begin
            mask <= mask - 1'b1;
          end
        end
        ST_RDA: state <= ST_UPA;
        ST_UPA: begin
          delta <= delta + contrib;
          state <= is_move ? ST_RDB : ST_NXT;
        end
        ST_RDB: state <= ST_UPB;
        ST_UPB: begin
          delta <= delta + contrib;
          state <= ST_NXT;
        end
        ST_NXT: begin
          if (!carry) begin
            k     <= k_next;
            state <= ST_RDA;
          end else if (mask == '0) begin
            if (d == obce_pkg::DIG_W'(obce_pkg::Q - 1)) begin
              state <= ST_FIN;
            end else begin
              d     <= d + 1'b1;
              state <= ST_BALL;
            end
          end else begin
            mask  <= mask - 1'b1;
            state <= ST_MASK;
          end
        end
        ST_FIN: begin
          if (!out_valid) begin
            if (!cur.skip && (cur.cmd != obce_pkg::CMD_EST)) begin
              total     <= (tsum < 0) ? '0 : obce_pkg::TOT_W'(tsum);
              out_total <= (tsum < 0) ? '0 : obce_pkg::TOT_W'(tsum);
            end else begin
              out_total <= total;
            end
            out_delta <= delta;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  obce_ram #(.W(obce_pkg::CNT_W), .D(obce_pkg::DEPTH)) u_counts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  obce_ram #(.W(obce_pkg::WORD_W), .D(obce_pkg::MAX_ORBITS)) u_reps (
    .clk   (clk),
    .we    (rep_we),
    .waddr (rep_waddr),
    .wdata (rep_wdata),
    .raddr (q.entry.orbit),
    .rdata (rep_rdata)
  );

`ifndef NO_ASSERTIONS
  a_est_no_write: assert property (@(posedge clk) disable iff (rst)
    (cnt_we && (state != ST_CLEAR)) |-> (cur.cmd != obce_pkg::CMD_EST))
    else $error("counter written during estimate");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> q.valid)
    else $error("pop from empty queue");
  a_clear_no_pop: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !pop)
    else $error("command taken during clear");
  a_fin_result: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FIN) && !out_valid) |=> out_valid)
    else $error("result not posted");
`endif

endmodule

>>> sv/orbit_ball_coverage_engine.sv
// channel   dir  tdata fields (low bit up)                          tuser
// s_axis    in   cmd[1:0] orbit[7:2] word[19:8] position[22:20]     -
//                new_digit[24:23], zero fill to 32
// m_axis    out  delta_uncovered[13:0] uncovered_total[26:14],      -
//                zero fill to 32
// cfg       in   cfg_we / cfg_wdata: radius, 3 bits
//
// one command at a time: each Hamming ball scans 64 position masks, then walks
// each point on the counter ram through RDA, UPA, NXT (place/remove) or RDA,
// UPA, RDB, UPB, NXT (move: reads the walked point and its partner; a commit
// writes both back)
// after reset a clearing pass zeroes all 4096 counters; input held off
// a two-entry queue sits between decode and the walker; output is registered
module orbit_ball_coverage_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // cmd, orbit, word, position, new_digit from bit 0 up
  input  logic [obce_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // delta_uncovered, uncovered_total from bit 0 up
  output logic [obce_pkg::OUT_W-1:0]    m_axis_tdata,
  input  logic                          cfg_we,
  input  logic [obce_pkg::RAD_W-1:0]    cfg_wdata
);

  logic [obce_pkg::RAD_W-1:0]           radius;
  obce_pkg::queue_out_t                 q;
  obce_pkg::back_stat_t                 stat;
  logic signed [obce_pkg::DELTA_W-1:0]  out_delta;
  logic [obce_pkg::TOT_W-1:0]           out_total;

  // covering radius register
  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= obce_pkg::RAD_W'(1);
    end else if (cfg_we) begin
      radius <= cfg_wdata;
    end
  end

  // decode and queue
  obce_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .stat          (stat),
    .q             (q)
  );

  // ball walker and counters
  obce_back u_back (
    .clk       (clk),
    .rst       (rst),
    .radius    (radius),
    .q         (q),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_delta (out_delta),
    .out_total (out_total)
  );

  assign m_axis_tdata = {
    (obce_pkg::OUT_W - obce_pkg::DELTA_W - obce_pkg::TOT_W)'(0),
    out_total, out_delta
  };

endmodule
